// ----- rtl/rtb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtb_pkg : shared types and constants of the reload timer bank
// Command codes, fixed field widths and the control struct that the top level
// hands to each timer lane.
// ----------------------------------------------------------------------------
package rtb_pkg;

    // Fixed field widths of the request and result
    localparam int CMD_W       = 2;
    localparam int INDEX_W     = 3;
    localparam int IN_COUNT_W  = 32;
    localparam int OUT_COUNT_W = 32;
    localparam int MASK_W      = 8;

    // Command codes; the fourth code is unused and changes nothing
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Per-lane control, valid for one cycle
    typedef struct packed {
        logic tick;   // decrement if running
        logic start;  // load count, reload and notify from the request
    } t_lane_ctl;

endpackage

// ----- rtl/rtb_timer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtb_timer : one down-counting timer lane with auto-reload
// Holds count, reload value and notify bit. On a tick a running count steps
// down; a tick on a count of one loads the reload value and, if notify is set, flags expiry.
// ----------------------------------------------------------------------------
module rtb_timer
    import rtb_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_lane_ctl              i_ctl,
    input  logic [COUNT_WIDTH-1:0] i_start_count,
    input  logic [COUNT_WIDTH-1:0] i_reload_count,
    input  logic                   i_notify_enable,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic                   o_notify
);

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [COUNT_WIDTH-1:0] r_reload, n_reload;
    logic                   r_notify, n_notify;
    logic                   expire;

    // Expiry: a tick on a count of exactly one
    assign expire = i_ctl.tick && (r_count == COUNT_WIDTH'(1));

    // Next state
    always_comb begin
        n_count  = r_count;
        n_reload = r_reload;
        n_notify = r_notify;
        if (i_ctl.start) begin
            n_count  = i_start_count;
            n_reload = i_reload_count;
            n_notify = i_notify_enable;
        end else if (expire) begin
            n_count  = r_reload;
        end else if (i_ctl.tick && (r_count != '0)) begin
            n_count  = r_count - COUNT_WIDTH'(1);
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_reload <= '0;
            r_notify <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_reload <= n_reload;
            r_notify <= n_notify;
        end
    end

    assign o_count  = r_count;
    assign o_notify = expire && r_notify;

endmodule

// ----- rtl/reload_timer_bank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reload_timer_bank : bank of auto-reload down-counting timers
// Tick, start and read requests over a valid/stall channel; one result per
// request carrying a read count and an expiry mask.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  request   in         i_in_valid / o_in_stall   cmd, timer_index, start_count,
//                                                 reload_count, notify_enable
//  result    out        o_out_valid / i_out_stall read_count, expired_mask
//
//  One request per cycle sustained while the result is not stalled; a request
//  passes the input register, then the lane update and result register in one pass.
//  Reset clears every timer's count, reload value and notify bit.
//  A stall on the result holds the result register and the request waiting
//  in the input register; further requests stall until it moves on.
// ----------------------------------------------------------------------------
module reload_timer_bank
    import rtb_pkg::*;
#(
    parameter int NUM_TIMERS  = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [CMD_W-1:0]       i_cmd,
    input  logic [INDEX_W-1:0]     i_timer_index,
    input  logic [IN_COUNT_W-1:0]  i_start_count,
    input  logic [IN_COUNT_W-1:0]  i_reload_count,
    input  logic                   i_notify_enable,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [OUT_COUNT_W-1:0] o_read_count,
    output logic [MASK_W-1:0]      o_expired_mask
);

    localparam int ADDR_LANES = (NUM_TIMERS < (1 << INDEX_W)) ? NUM_TIMERS : (1 << INDEX_W);
    localparam int MASK_LANES = (NUM_TIMERS < MASK_W) ? NUM_TIMERS : MASK_W;

    // Input register
    logic                  r_in_valid;
    logic [CMD_W-1:0]      r_cmd;
    logic [INDEX_W-1:0]    r_index;
    logic [IN_COUNT_W-1:0] r_start_count;
    logic [IN_COUNT_W-1:0] r_reload_count;
    logic                  r_notify_enable;

    // Result register
    logic                   r_out_valid;
    logic [OUT_COUNT_W-1:0] r_read_count, n_read_count;
    logic [MASK_W-1:0]      r_expired_mask, n_expired_mask;

    logic advance;
    logic fire;

    logic [COUNT_WIDTH-1:0] start_cw;
    logic [COUNT_WIDTH-1:0] reload_cw;
    logic [COUNT_WIDTH-1:0] lane_count  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  lane_notify;
    logic [OUT_COUNT_W-1:0] lane_rd     [NUM_TIMERS];

    // Flow control: the result register can take a new result
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_cmd           <= i_cmd;
            r_index         <= i_timer_index;
            r_start_count   <= i_start_count;
            r_reload_count  <= i_reload_count;
            r_notify_enable <= i_notify_enable;
        end
    end

    assign start_cw  = COUNT_WIDTH'(r_start_count);
    assign reload_cw = COUNT_WIDTH'(r_reload_count);

    // Timer lanes
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_lane
        t_lane_ctl ctl;
        logic      sel;

        // Only the first lanes are reachable through the index field
        if (g < ADDR_LANES) begin : g_addr
            assign sel = (r_index == INDEX_W'(g));
        end else begin : g_noaddr
            assign sel = 1'b0;
        end

        assign ctl.tick  = fire && (r_cmd == CMD_TICK);
        assign ctl.start = fire && (r_cmd == CMD_START) && sel;

        rtb_timer #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_timer (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (ctl),
            .i_start_count   (start_cw),
            .i_reload_count  (reload_cw),
            .i_notify_enable (r_notify_enable),
            .o_count         (lane_count[g]),
            .o_notify        (lane_notify[g])
        );

        // AND-OR read select, low bits of the count
        assign lane_rd[g] = sel ? OUT_COUNT_W'(lane_count[g]) : '0;
    end

    // Result values
    always_comb begin
        n_read_count   = '0;
        n_expired_mask = '0;
        case (r_cmd)
            CMD_TICK: begin
                for (int i = 0; i < MASK_LANES; i++) begin
                    n_expired_mask[i] = lane_notify[i];
                end
            end
            CMD_READ: begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    n_read_count = n_read_count | lane_rd[i];
                end
            end
            default: begin
                n_read_count   = '0;
                n_expired_mask = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_read_count   <= n_read_count;
            r_expired_mask <= n_expired_mask;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_count   = r_read_count;
    assign o_expired_mask = r_expired_mask;

endmodule
